// ===== sv/button_press_classifier_core_macros.svh =====
// assertion macros for the button press classifier
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bpc_pkg.sv =====
// types and constants shared by the button press classifier modules
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 2;
  localparam int InDataW  = 40;
  localparam int OutDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MAX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_MIN  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_VLONG_MIN = 2'd3;

  localparam logic [CfgW-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CfgW-1:0] SHORT_MAX_RST = 16'd1000;
  localparam logic [CfgW-1:0] LONG_MIN_RST  = 16'd1500;
  localparam logic [CfgW-1:0] VLONG_MIN_RST = 16'd3000;

  typedef enum logic [1:0] {
    CLASS_NONE  = 2'd0,
    CLASS_SHORT = 2'd1,
    CLASS_LONG  = 2'd2,
    CLASS_VLONG = 2'd3
  } press_class_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] short_max_ms;
    logic [CfgW-1:0] long_min_ms;
    logic [CfgW-1:0] very_long_min_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] last_accept_time;
    logic             prev_level;
    logic [TimeW-1:0] press_start_time;
    logic             screen_on;
    logic             auto_on;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             pin_level;
  } event_t;

  typedef struct packed {
    logic         screen_is_on;
    logic         auto_mode;
    logic         screen_sleep;
    logic         screen_wake;
    logic         next_frame_request;
    press_class_t press_class;
    logic         ignored;
  } result_t;

endpackage

// ===== sv/bpc_cfg_regs.sv =====
// configuration register file of the button press classifier
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bpc_pkg::CfgW-1:0]     cfg_data,
  output bpc_pkg::cfg_t                cfg
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DEBOUNCE_RST;
      cfg.short_max_ms     <= SHORT_MAX_RST;
      cfg.long_min_ms      <= LONG_MIN_RST;
      cfg.very_long_min_ms <= VLONG_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg.debounce_ms      <= cfg_data;
        REG_SHORT_MAX: cfg.short_max_ms     <= cfg_data;
        REG_LONG_MIN:  cfg.long_min_ms      <= cfg_data;
        REG_VLONG_MIN: cfg.very_long_min_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bpc_eval.sv =====
// debounce, edge detect and press classification for one event
`timescale 1ns / 1ps

module bpc_eval (
  input  bpc_pkg::cfg_t   cfg,
  input  bpc_pkg::state_t st,
  input  bpc_pkg::event_t ev,
  output bpc_pkg::state_t st_next,
  output bpc_pkg::result_t res
);
  import bpc_pkg::*;

  logic [TimeW-1:0] since_last;
  logic [TimeW-1:0] dur;
  logic             is_ignored;
  logic             fall_edge;
  logic             rise_edge;
  logic             dur_ok;
  logic             hit_short;
  logic             hit_long;
  logic             hit_vlong;
  logic             screen_mid;

  assign since_last = ev.time_ms - st.last_accept_time;
  assign dur        = ev.time_ms - st.press_start_time;
  assign is_ignored = since_last < {16'd0, cfg.debounce_ms};
  assign fall_edge  = st.prev_level && !ev.pin_level;
  assign rise_edge  = !st.prev_level && ev.pin_level;
  // negative length never classifies
  assign dur_ok     = !is_ignored && rise_edge && !dur[TimeW-1];
  assign hit_short  = dur_ok && (dur > {16'd0, cfg.debounce_ms})
                      && (dur < {16'd0, cfg.short_max_ms});
  assign hit_long   = dur_ok && (dur > {16'd0, cfg.long_min_ms})
                      && (dur < {16'd0, cfg.very_long_min_ms});
  assign hit_vlong  = dur_ok && (dur >= {16'd0, cfg.very_long_min_ms});

  // screen state between the short and very long actions
  assign screen_mid = st.screen_on | hit_short;

  always_comb begin
    st_next = st;
    if (!is_ignored) begin
      st_next.last_accept_time = ev.time_ms;
      st_next.prev_level       = ev.pin_level;
      if (fall_edge) begin
        st_next.press_start_time = ev.time_ms;
      end
    end
    st_next.auto_on   = st.auto_on ^ hit_long;
    st_next.screen_on = screen_mid & ~hit_vlong;

    res.ignored            = is_ignored;
    res.next_frame_request = hit_short & st.screen_on;
    res.screen_wake        = hit_short & ~st.screen_on;
    res.screen_sleep       = hit_vlong & screen_mid;
    res.auto_mode          = st_next.auto_on;
    res.screen_is_on       = st_next.screen_on;
    if (hit_vlong) begin
      res.press_class = CLASS_VLONG;
    end else if (hit_long) begin
      res.press_class = CLASS_LONG;
    end else if (hit_short) begin
      res.press_class = CLASS_SHORT;
    end else begin
      res.press_class = CLASS_NONE;
    end
  end

endmodule

// ===== sv/button_press_classifier_core.sv =====
// top level of the button press classifier
//
// usage:
//   s_tvalid/s_tready/s_tdata carry pin change events, one per transfer:
//   s_tdata[31:0] timestamp in ms, s_tdata[32] pin level (0 pressed).
//   m_tvalid/m_tready/m_tdata return exactly one result per event, in order.
//   cfg_we/cfg_index/cfg_data write the four window registers
//   (debounce, short max, long min, very long min) while the block is idle.
// path: from the input transfer to m_tvalid an event passes the input register,
//   then the result register that also updates the press state.
// throughput: one event per cycle while m_tready is high; the only feedback
//   path is the press state, which settles within the evaluation cycle.
// reset: synchronous; screen on, auto mode off, level released, timestamps
//   zero, registers at 50, 1000, 1500 and 3000 ms; no results pending.
// stall: while a result waits on m_tready the evaluation stage holds, and
//   an empty input register still takes one more event before s_tready
//   drops.
`timescale 1ns / 1ps

`include "button_press_classifier_core_macros.svh"

module button_press_classifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // time_ms[31:0], pin_level[32], zero fill[39:33]
  input  logic [bpc_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ignored[0], press_class[2:1], next_frame_request[3], screen_wake[4],
  // screen_sleep[5], auto_mode[6], screen_is_on[7]
  output logic [bpc_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgW-1:0]      cfg_data
);
  import bpc_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  event_t  ev;
  result_t res_next;
  result_t res;
  logic    in_valid;
  logic    out_valid;
  logic    advance;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_eval u_eval (
    .cfg     (cfg),
    .st      (st),
    .ev      (ev),
    .st_next (st_next),
    .res     (res_next)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      ev.time_ms   <= s_tdata[TimeW-1:0];
      ev.pin_level <= s_tdata[TimeW];
    end
  end

  // press state, updated with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.last_accept_time <= '0;
      st.prev_level       <= 1'b1;
      st.press_start_time <= '0;
      st.screen_on        <= 1'b1;
      st.auto_on          <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = res;

  `BPC_ASSERT_NOW(a_flags_track_state, out_valid,
    (res.screen_is_on == st.screen_on) && (res.auto_mode == st.auto_on),
    "result flags differ from press state")
  `BPC_ASSERT_NEXT(a_stall_holds_state, out_valid && !m_tready, $stable(st),
    "press state moved while result stalled")
  `BPC_ASSERT_NOW(a_no_take_when_full, in_valid && !advance, !s_tready,
    "input taken while input register blocked")
  `BPC_ASSERT_NEXT(a_ignored_keeps_state, advance && res_next.ignored, $stable(st),
    "debounced event changed press state")

endmodule

// ===== tb/bpc_press_checker.sv =====
// checker for the button press classifier: predicts each result and compares the output stream
`timescale 1ns / 1ps

module bpc_press_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [bpc_pkg::InDataW-1:0]  s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [bpc_pkg::OutDataW-1:0] m_tdata,
  input  logic                         cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bpc_pkg::CfgW-1:0]     cfg_data,
  output int                           fail_count,
  output int                           backlog
);
  import bpc_pkg::*;

  cfg_t    windows;
  state_t  btn;
  result_t outcome_q[$];

  function automatic result_t classify_event(input logic [TimeW-1:0] now, input logic level);
    result_t          r;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] dur;
    r = '0;
    r.press_class = CLASS_NONE;
    elapsed = now - btn.last_accept_time;
    if (elapsed < {16'd0, windows.debounce_ms}) begin
      r.ignored = 1'b1;
    end else begin
      btn.last_accept_time = now;
      if (btn.prev_level && !level) begin
        btn.press_start_time = now;
      end else if (!btn.prev_level && level) begin
        dur = now - btn.press_start_time;
        // release before press in modulo time: no class
        if (!dur[TimeW-1]) begin
          if (dur > {16'd0, windows.debounce_ms} && dur < {16'd0, windows.short_max_ms}) begin
            r.press_class = CLASS_SHORT;
            if (!btn.screen_on) begin
              btn.screen_on = 1'b1;
              r.screen_wake = 1'b1;
            end else begin
              r.next_frame_request = 1'b1;
            end
          end
          if (dur > {16'd0, windows.long_min_ms} && dur < {16'd0, windows.very_long_min_ms}) begin
            r.press_class = CLASS_LONG;
            btn.auto_on = ~btn.auto_on;
          end
          if (dur >= {16'd0, windows.very_long_min_ms}) begin
            r.press_class = CLASS_VLONG;
            if (btn.screen_on) begin
              btn.screen_on = 1'b0;
              r.screen_sleep = 1'b1;
            end
          end
        end
      end
      btn.prev_level = level;
    end
    r.auto_mode = btn.auto_on;
    r.screen_is_on = btn.screen_on;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      windows.debounce_ms = DEBOUNCE_RST;
      windows.short_max_ms = SHORT_MAX_RST;
      windows.long_min_ms = LONG_MIN_RST;
      windows.very_long_min_ms = VLONG_MIN_RST;
      btn.last_accept_time = '0;
      btn.prev_level = 1'b1;
      btn.press_start_time = '0;
      btn.screen_on = 1'b1;
      btn.auto_on = 1'b0;
      outcome_q.delete();
      fail_count = 0;
      backlog = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer, expected nothing actual %0h", $time, m_tdata);
        end else begin
          want = outcome_q.pop_front();
          check_field("ignored", want.ignored, got.ignored);
          check_field("press_class", want.press_class, got.press_class);
          check_field("next_frame_request", want.next_frame_request, got.next_frame_request);
          check_field("screen_wake", want.screen_wake, got.screen_wake);
          check_field("screen_sleep", want.screen_sleep, got.screen_sleep);
          check_field("auto_mode", want.auto_mode, got.auto_mode);
          check_field("screen_is_on", want.screen_is_on, got.screen_is_on);
        end
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(classify_event(s_tdata[TimeW-1:0], s_tdata[TimeW]));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:  windows.debounce_ms = cfg_data;
          REG_SHORT_MAX: windows.short_max_ms = cfg_data;
          REG_LONG_MIN:  windows.long_min_ms = cfg_data;
          REG_VLONG_MIN: windows.very_long_min_ms = cfg_data;
          default: ;
        endcase
      end
      backlog = outcome_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// top of the button press classifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // time_ms[31:0], pin_level[32], zero fill[39:33]
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // ignored[0], press_class[2:1], next_frame_request[3], screen_wake[4],
  // screen_sleep[5], auto_mode[6], screen_is_on[7]
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = REG_DEBOUNCE;
  logic [CfgW-1:0]     cfg_data = '0;
  int                  fail_count;
  int                  backlog;

  int tx_idle_pct = 26;
  int rx_idle_pct = 84;

  logic [CfgW-1:0]  db_ms = DEBOUNCE_RST;
  logic [CfgW-1:0]  short_ms = SHORT_MAX_RST;
  logic [CfgW-1:0]  long_ms = LONG_MIN_RST;
  logic [CfgW-1:0]  vlong_ms = VLONG_MIN_RST;
  logic [TimeW-1:0] clock_ms = '0;

  button_press_classifier_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpc_press_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_event(input logic [TimeW-1:0] t, input logic lvl);
    logic ok;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, lvl, t};
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_windows(input logic [CfgW-1:0] db, input logic [CfgW-1:0] sm,
                             input logic [CfgW-1:0] lm, input logic [CfgW-1:0] vl);
    logic [CfgW-1:0]    vals [4];
    logic [CfgIdxW-1:0] idx [4];
    vals = '{db, sm, lm, vl};
    idx = '{REG_DEBOUNCE, REG_SHORT_MAX, REG_LONG_MIN, REG_VLONG_MIN};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    db_ms = db;
    short_ms = sm;
    long_ms = lm;
    vlong_ms = vl;
  endtask

  // press lengths clustered on the window edges, plus wide and negative ones
  function automatic logic [TimeW-1:0] pick_duration();
    logic [TimeW-1:0] d;
    case ($urandom_range(11))
      0:       d = {16'd0, db_ms};
      1:       d = {16'd0, db_ms} + 1;
      2:       d = {16'd0, short_ms} - 1;
      3:       d = {16'd0, short_ms};
      4:       d = {16'd0, long_ms};
      5:       d = {16'd0, long_ms} + 1;
      6:       d = {16'd0, vlong_ms} - 1;
      7:       d = {16'd0, vlong_ms};
      8:       d = $urandom_range(0, 4000);
      9:       d = $urandom_range(0, 70000);
      10:      d = $urandom;
      default: d = 32'h8000_0000 + $urandom_range(0, 1000);
    endcase
    return d;
  endfunction

  task automatic run_presses(input int count);
    int               made;
    int               pick;
    logic [TimeW-1:0] press_t;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(9) == 0) clock_ms = clock_ms + $urandom_range(0, 70000);
        else clock_ms = clock_ms + db_ms + $urandom_range(1, 300);
        press_t = clock_ms;
        send_event(press_t, 1'b0);
        // contact bounce inside the debounce window
        if (db_ms > 1 && $urandom_range(2) == 0) begin
          send_event(press_t + $urandom_range(0, db_ms - 1), $urandom_range(1) == 1);
          made++;
        end
        clock_ms = press_t + pick_duration();
        send_event(clock_ms, 1'b1);
        made += 2;
      end else if (pick < 92) begin
        clock_ms = clock_ms + $urandom_range(0, 2 * db_ms + 20);
        send_event(clock_ms, $urandom_range(1) == 1);
        made++;
      end else begin
        clock_ms = $urandom;
        send_event(clock_ms, $urandom_range(1) == 1);
        made++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset windows
    send_event(32'd0, 1'b0);
    send_event(32'd49, 1'b0);
    send_event(32'd50, 1'b1);
    send_event(32'd100, 1'b0);
    send_event(32'd150, 1'b1);
    send_event(32'd200, 1'b0);
    send_event(32'd251, 1'b1);
    send_event(32'd300, 1'b0);
    send_event(32'd3300, 1'b1);
    send_event(32'd4000, 1'b0);
    send_event(32'd4030, 1'b1);
    send_event(32'd4500, 1'b1);
    send_event(32'd5000, 1'b0);
    send_event(32'd6501, 1'b1);
    send_event(32'd7000, 1'b0);
    send_event(32'd8500, 1'b1);
    send_event(32'd10000, 1'b0);
    send_event(32'd11000, 1'b1);
    send_event(32'd12000, 1'b0);
    send_event(32'd12100, 1'b0);
    send_event(32'd14999, 1'b1);
    send_event(32'hFFFF_0000, 1'b0);
    send_event(32'h0000_0100, 1'b1);
    send_event(32'h0000_1000, 1'b0);
    send_event(32'h8000_1000, 1'b1);
    send_event(32'hFFFF_FFFF, 1'b1);
    clock_ms = 32'hFFFF_FFFF;

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 84 : 0;
      rx_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 26 : 0;
      for (int setting = 0; setting < 6; setting++) begin
        drain_results();
        case (setting)
          0: set_windows(DEBOUNCE_RST, SHORT_MAX_RST, LONG_MIN_RST, VLONG_MIN_RST);
          1: set_windows(16'd0, 16'd0, 16'd0, 16'd0);
          2: set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: set_windows(16'd200, 16'd5000, 16'd100, 16'd400);
          4: set_windows(16'($urandom_range(0, 300)), 16'($urandom_range(0, 8000)),
                         16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)));
          default: set_windows(16'd10, 16'hFFFF, 16'd0, 16'hFFFF);
        endcase
        run_presses(92);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("button_press_classifier_core regression: pass");
    end else begin
      $display("button_press_classifier_core regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("button_press_classifier_core regression: fail");
    $finish;
  end

endmodule
